// ===== rtl/multi_slot_ack_retry_engine_assert.svh =====
// Assertion macros for the multi-slot retry engine.
// Used by the top level; relies on signals named clk and rst_n in scope.
`ifndef MULTI_SLOT_ACK_RETRY_ENGINE_ASSERT_SVH
`define MULTI_SLOT_ACK_RETRY_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSARE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msare assertion failed");
`define MSARE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msare assertion failed");
`else
`define MSARE_ASSERT_IMPLY(label, ante, cons)
`define MSARE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/msare_pkg.sv =====
// Package for the multi-slot retry engine: codes, reset values and the
// structs used by the slot cell and the top level. No dependencies.
`timescale 1ns / 1ps
package msare_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd2500;
  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd5;
  localparam logic [15:0] BUSY_BACKOFF_RST = 16'd500;
  localparam logic [15:0] SEQ_START_RST = 16'h0100;

  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
  localparam logic [1:0] REG_BUSY_BACKOFF = 2'd2;
  localparam logic [1:0] REG_SEQ_START = 2'd3;

  localparam logic [1:0] CLS_OK = 2'd0;
  localparam logic [1:0] CLS_BUSY = 2'd1;
  localparam logic [1:0] CLS_ERROR = 2'd2;
  localparam logic [1:0] CLS_WAIT = 2'd3;

  localparam logic [1:0] EV_SEND = 2'd0;
  localparam logic [1:0] EV_PROGRESS = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REPLY = 2'd1,
    OP_ADD = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] from;
    logic [15:0] rseq;
    logic [1:0]  rcls;
    logic [15:0] seq_in;
    logic [15:0] ack_to;
    logic [15:0] backoff;
    logic [3:0]  max_att;
  } cell_cmd_t;

  typedef struct packed {
    logic        send;
    logic        prog;
    logic        done_inc;
    logic        ok_inc;
    logic [31:0] peer;
    logic [23:0] preset;
  } cell_rep_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [31:0] dest;
    logic [15:0] seq;
    logic [15:0] pid;
    logic [7:0]  psub;
    logic [7:0]  scene;
    logic [6:0]  okc;
    logic [6:0]  tot;
    logic        allok;
  } res_t;

endpackage

// ===== rtl/msare_cell.sv =====
// One slot of the retry engine: holds the slot state and updates it while
// it holds the walk token, which it hands to the next cell. Uses msare_pkg.
`timescale 1ns / 1ps
module msare_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  logic [31:0]         wr_peer,
  input  logic [23:0]         wr_preset,
  input  logic                start,
  input  logic                tok_load,
  input  logic                adv,
  input  logic                tok_in,
  input  msare_pkg::cell_cmd_t cmd,
  output logic                tok_out,
  output msare_pkg::cell_rep_t rep
);

  logic [31:0] peer_r;
  logic [23:0] preset_r;
  logic [15:0] seq_r, seq_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] boff_r, boff_nxt;
  logic        aw_r, aw_nxt, done_r, done_nxt, ok_r, ok_nxt;
  logic        tok_r, tok_nxt;
  logic        en;

  assign en = tok_r && adv;
  assign tok_out = tok_r;

  always_comb begin
    seq_nxt = seq_r;
    att_nxt = att_r;
    wait_nxt = wait_r;
    boff_nxt = boff_r;
    aw_nxt = aw_r;
    done_nxt = done_r;
    ok_nxt = ok_r;
    rep = '0;
    rep.peer = peer_r;
    rep.preset = preset_r;
    unique case (cmd.op)
      msare_pkg::OP_TICK: begin
        if (!done_r) begin
          wait_nxt = (wait_r != 16'd0) ? wait_r - 16'd1 : 16'd0;
          boff_nxt = (boff_r != 16'd0) ? boff_r - 16'd1 : 16'd0;
          if (aw_r && wait_nxt != 16'd0) begin
            aw_nxt = 1'b1;
          end else begin
            aw_nxt = 1'b0;
            if (boff_nxt != 16'd0) begin
              aw_nxt = 1'b0;
            end else if (att_r >= cmd.max_att) begin
              done_nxt = 1'b1;
              ok_nxt = 1'b0;
              rep.done_inc = 1'b1;
            end else begin
              att_nxt = att_r + 4'd1;
              seq_nxt = cmd.seq_in;
              aw_nxt = 1'b1;
              wait_nxt = cmd.ack_to;
              rep.send = 1'b1;
            end
          end
        end
      end
      msare_pkg::OP_REPLY: begin
        if (!done_r && aw_r && seq_r == cmd.rseq && peer_r == cmd.from) begin
          rep.prog = 1'b1;
          if (cmd.rcls == msare_pkg::CLS_OK) begin
            done_nxt = 1'b1;
            ok_nxt = 1'b1;
            aw_nxt = 1'b0;
            rep.done_inc = 1'b1;
            rep.ok_inc = 1'b1;
          end else if (cmd.rcls == msare_pkg::CLS_BUSY) begin
            aw_nxt = 1'b0;
            boff_nxt = cmd.backoff;
          end else if (cmd.rcls == msare_pkg::CLS_ERROR) begin
            done_nxt = 1'b1;
            ok_nxt = 1'b0;
            aw_nxt = 1'b0;
            rep.done_inc = 1'b1;
          end
        end
      end
      msare_pkg::OP_COMMIT: begin
        seq_nxt = 16'd0;
        att_nxt = 4'd0;
        wait_nxt = 16'd0;
        boff_nxt = 16'd0;
        aw_nxt = 1'b0;
        ok_nxt = 1'b0;
        done_nxt = (peer_r == 32'd0);
        rep.done_inc = (peer_r == 32'd0);
      end
      default: begin
        aw_nxt = aw_r;
      end
    endcase
  end

  always_comb begin
    if (start) begin
      tok_nxt = tok_load;
    end else if (adv) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      peer_r <= wr_peer;
      preset_r <= wr_preset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      seq_r <= '0;
      att_r <= '0;
      wait_r <= '0;
      boff_r <= '0;
      aw_r <= 1'b0;
      done_r <= 1'b0;
      ok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (en) begin
        seq_r <= seq_nxt;
        att_r <= att_nxt;
        wait_r <= wait_nxt;
        boff_r <= boff_nxt;
        aw_r <= aw_nxt;
        done_r <= done_nxt;
        ok_r <= ok_nxt;
      end
    end
  end

endmodule

// ===== rtl/multi_slot_ack_retry_engine.sv =====
// Top level of the multi-slot retry engine: job control, walk sequencer and
// result registers. Uses msare_pkg, msare_cell and the assertion header.
// Add slot and an inactive tick or reply leave the sequencer idle; a valid commit walks
// the list to reset the cells. An active tick or reply walks the cells one per cycle,
// then posts a done result once all slots are done and flushes the last result before
// taking new input. Result stalls stretch the walk; at most one result leaves per cycle.
// Synchronous active-low reset clears the job and all slot flags at once.
`timescale 1ns / 1ps
`include "multi_slot_ack_retry_engine_assert.svh"
module multi_slot_ack_retry_engine #(
  parameter int NUM_SLOTS = msare_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_peer_ip,
  input  logic [15:0] in_preset_id,
  input  logic [7:0]  in_preset_sub,
  input  logic [7:0]  in_scene_index,
  input  logic        in_scene_valid,
  input  logic [15:0] in_reply_seq,
  input  logic [1:0]  in_reply_class,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [5:0]  out_slot_index,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_seq,
  output logic [15:0] out_preset_id,
  output logic [7:0]  out_preset_sub,
  output logic [7:0]  out_job_scene,
  output logic [6:0]  out_ok_count,
  output logic [6:0]  out_total,
  output logic        out_all_ok,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef msare_pkg::op_t op_t;

  msare_pkg::state_t state_r, state_nxt;
  logic [15:0] ack_to_r, backoff_r, seq_cnt_r;
  logic [3:0]  max_att_r;
  logic        active_r, closed_r;
  logic [CW-1:0] count_r, idx_r, done_cnt_r, ok_cnt_r, count_eff;
  logic [7:0]  scene_r;
  msare_pkg::op_t op_r;
  logic [31:0] from_r;
  logic [15:0] rseq_r;
  logic [1:0]  rcls_r;
  msare_pkg::res_t pend_r, out_r, new_res, done_res;
  logic        pend_v_r, out_valid_r, out_last_r;
  logic        in_fire, out_free, step, start, walk_end, fin_done, add_fire;
  logic        out_load;
  msare_pkg::cell_cmd_t cmd;
  msare_pkg::cell_rep_t rep;
  msare_pkg::cell_rep_t reps [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tok;
  logic [NUM_SLOTS-1:0] wr_sel;

  assign in_fire = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign count_eff = closed_r ? '0 : count_r;
  assign add_fire = in_fire && op_t'(in_func) == msare_pkg::OP_ADD && !active_r &&
                    count_eff < CW'(NUM_SLOTS);
  assign walk_end = (idx_r == count_r - CW'(1));
  assign fin_done = (done_cnt_r == count_r);

  assign cmd.op = op_r;
  assign cmd.from = from_r;
  assign cmd.rseq = rseq_r;
  assign cmd.rcls = rcls_r;
  assign cmd.seq_in = seq_cnt_r + 16'd1;
  assign cmd.ack_to = ack_to_r;
  assign cmd.backoff = backoff_r;
  assign cmd.max_att = max_att_r;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    assign wr_sel[i] = add_fire && (count_eff == CW'(i));
    msare_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr_sel[i]),
      .wr_peer  (in_peer_ip),
      .wr_preset({in_preset_id, in_preset_sub}),
      .start    (start),
      .tok_load (i == 0),
      .adv      (step),
      .tok_in   ((i == 0) ? 1'b0 : tok[(i == 0) ? 0 : i - 1]),
      .cmd      (cmd),
      .tok_out  (tok[i]),
      .rep      (reps[i])
    );
  end

  always_comb begin
    rep = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rep = rep | (reps[i] & {$bits(msare_pkg::cell_rep_t){tok[i]}});
    end
  end

  always_comb begin
    new_res = '0;
    new_res.slot = 6'(idx_r);
    new_res.scene = scene_r;
    if (rep.send) begin
      new_res.kind = msare_pkg::EV_SEND;
      new_res.dest = rep.peer;
      new_res.seq = cmd.seq_in;
      new_res.pid = rep.preset[23:8];
      new_res.psub = rep.preset[7:0];
    end else begin
      new_res.kind = msare_pkg::EV_PROGRESS;
      new_res.okc = 7'(ok_cnt_r + CW'(rep.ok_inc));
      new_res.tot = 7'(count_r);
    end
    done_res = '0;
    done_res.kind = msare_pkg::EV_DONE;
    done_res.scene = scene_r;
    done_res.okc = 7'(ok_cnt_r);
    done_res.tot = 7'(count_r);
    done_res.allok = (ok_cnt_r == count_r) && (count_r != '0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msare_pkg::ST_IDLE: begin
        if (in_fire && active_r &&
            (op_t'(in_func) == msare_pkg::OP_TICK ||
             op_t'(in_func) == msare_pkg::OP_REPLY)) begin
          state_nxt = (count_r == '0) ? msare_pkg::ST_FIN : msare_pkg::ST_WALK;
        end else if (in_fire && op_t'(in_func) == msare_pkg::OP_COMMIT &&
                     in_scene_valid && count_r != '0) begin
          state_nxt = msare_pkg::ST_WALK;
        end
      end
      msare_pkg::ST_WALK: begin
        if (step && walk_end) begin
          state_nxt = (op_r == msare_pkg::OP_COMMIT) ? msare_pkg::ST_IDLE :
                      msare_pkg::ST_FIN;
        end
      end
      msare_pkg::ST_FIN: begin
        if (!pend_v_r || out_free) begin
          state_nxt = msare_pkg::ST_FLUSH;
        end
      end
      msare_pkg::ST_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = msare_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msare_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != msare_pkg::ST_IDLE);
    step = (state_r == msare_pkg::ST_WALK) && (!pend_v_r || out_free);
    start = (state_r == msare_pkg::ST_IDLE) && (state_nxt == msare_pkg::ST_WALK);
    out_load = (step && (rep.send || rep.prog) && pend_v_r) ||
               (state_r == msare_pkg::ST_FIN && out_free && fin_done && pend_v_r) ||
               (state_r == msare_pkg::ST_FLUSH && pend_v_r && out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msare_pkg::ST_IDLE;
      ack_to_r <= msare_pkg::ACK_TIMEOUT_RST;
      max_att_r <= msare_pkg::MAX_ATTEMPTS_RST;
      backoff_r <= msare_pkg::BUSY_BACKOFF_RST;
      seq_cnt_r <= msare_pkg::SEQ_START_RST;
      active_r <= 1'b0;
      closed_r <= 1'b0;
      count_r <= '0;
      scene_r <= '0;
      idx_r <= '0;
      done_cnt_r <= '0;
      ok_cnt_r <= '0;
      op_r <= msare_pkg::OP_TICK;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          msare_pkg::REG_ACK_TIMEOUT: ack_to_r <= cfg_wdata;
          msare_pkg::REG_MAX_ATTEMPTS: max_att_r <= cfg_wdata[3:0];
          msare_pkg::REG_BUSY_BACKOFF: backoff_r <= cfg_wdata;
          msare_pkg::REG_SEQ_START: seq_cnt_r <= cfg_wdata;
          default: ack_to_r <= ack_to_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        op_r <= op_t'(in_func);
        from_r <= in_peer_ip;
        rseq_r <= in_reply_seq;
        rcls_r <= in_reply_class;
        idx_r <= '0;
        if (add_fire) begin
          count_r <= count_eff + CW'(1);
          closed_r <= 1'b0;
        end else if (op_t'(in_func) == msare_pkg::OP_ADD && !active_r && closed_r) begin
          count_r <= '0;
          closed_r <= 1'b0;
        end
        if (op_t'(in_func) == msare_pkg::OP_COMMIT) begin
          if (in_scene_valid) begin
            active_r <= 1'b1;
            closed_r <= 1'b1;
            scene_r <= in_scene_index;
            done_cnt_r <= '0;
            ok_cnt_r <= '0;
          end else begin
            active_r <= 1'b0;
            closed_r <= 1'b0;
            count_r <= '0;
            scene_r <= '0;
          end
        end
      end
      if (step) begin
        idx_r <= idx_r + CW'(1);
        done_cnt_r <= done_cnt_r + CW'(rep.done_inc);
        ok_cnt_r <= ok_cnt_r + CW'(rep.ok_inc);
        if (rep.send) begin
          seq_cnt_r <= seq_cnt_r + 16'd1;
        end
        if (rep.send || rep.prog) begin
          if (pend_v_r) begin
            out_r <= pend_r;
            out_last_r <= 1'b0;
          end
          pend_r <= new_res;
          pend_v_r <= 1'b1;
        end
      end
      if (state_r == msare_pkg::ST_FIN && (!pend_v_r || out_free) && fin_done) begin
        active_r <= 1'b0;
        if (pend_v_r) begin
          out_r <= pend_r;
          out_last_r <= 1'b0;
        end
        pend_r <= done_res;
        pend_v_r <= 1'b1;
      end
      if (state_r == msare_pkg::ST_FLUSH && pend_v_r && out_free) begin
        out_r <= pend_r;
        out_last_r <= 1'b1;
        pend_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_kind = out_r.kind;
  assign out_slot_index = out_r.slot;
  assign out_dest_ip = out_r.dest;
  assign out_seq = out_r.seq;
  assign out_preset_id = out_r.pid;
  assign out_preset_sub = out_r.psub;
  assign out_job_scene = out_r.scene;
  assign out_ok_count = out_r.okc;
  assign out_total = out_r.tot;
  assign out_all_ok = out_r.allok;
  assign out_last = out_last_r;

  `MSARE_ASSERT_IMPLY(a_one_token, 1'b1, $onehot0(tok))
  `MSARE_ASSERT_IMPLY(a_walk_in_list, state_r == msare_pkg::ST_WALK, idx_r < count_r)
  `MSARE_ASSERT_IMPLY(a_ok_le_done, active_r, ok_cnt_r <= done_cnt_r)
  `MSARE_ASSERT_NEXT(a_flush_idle, state_r == msare_pkg::ST_FLUSH && !pend_v_r,
                     state_r == msare_pkg::ST_IDLE && !pend_v_r)

endmodule

// ===== tb/multi_slot_ack_retry_engine_tb.sv =====
// Self-checking testbench for multi_slot_ack_retry_engine: a scoreboard class predicts
// every send, progress and done transaction and checks the DUT output against it.
// Depends on msare_pkg and the RTL top level only.
`timescale 1ns / 1ps
module multi_slot_ack_retry_engine_tb;

  localparam int NSLOT = msare_pkg::NUM_SLOTS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT = 20000;
  localparam int TARGET_ITEMS = 300;

  typedef struct {
    msare_pkg::op_t func;
    logic [31:0] peer_ip;
    logic [15:0] pre_num;
    logic [7:0]  pre_sub;
    logic [7:0]  scn_num;
    logic        scene_valid;
    logic [15:0] reply_seq;
    logic [1:0]  reply_class;
  } req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [31:0] dest;
    logic [15:0] seq;
    logic [15:0] pid;
    logic [7:0]  psub;
    logic [7:0]  scene;
    logic [6:0]  okc;
    logic [6:0]  tot;
    logic        allok;
    logic        last;
  } evt_t;

  class arq_scoreboard;
    logic [15:0] ack_to;
    logic [3:0]  max_att;
    logic [15:0] backoff;
    logic [15:0] seq_ctr;
    logic [31:0] peer [NSLOT];
    logic [23:0] preset [NSLOT];
    logic [15:0] sseq [NSLOT];
    logic [3:0]  att [NSLOT];
    logic [15:0] wait_left [NSLOT];
    logic [15:0] hold_left [NSLOT];
    bit          awaiting [NSLOT];
    bit          done [NSLOT];
    bit          ok [NSLOT];
    bit          active;
    bit          closed;
    int          count;
    logic [7:0]  scene;
    evt_t        pending [$];
    int          sends;
    int          progresses;
    int          dones;

    function new();
      ack_to = msare_pkg::ACK_TIMEOUT_RST;
      max_att = msare_pkg::MAX_ATTEMPTS_RST;
      backoff = msare_pkg::BUSY_BACKOFF_RST;
      seq_ctr = msare_pkg::SEQ_START_RST;
      for (int i = 0; i < NSLOT; i++) begin
        sseq[i] = '0;
        att[i] = '0;
        wait_left[i] = '0;
        hold_left[i] = '0;
        awaiting[i] = 0;
        done[i] = 0;
        ok[i] = 0;
      end
      active = 0;
      closed = 0;
      count = 0;
      scene = '0;
      sends = 0;
      progresses = 0;
      dones = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        msare_pkg::REG_ACK_TIMEOUT: ack_to = val;
        msare_pkg::REG_MAX_ATTEMPTS: max_att = val[3:0];
        msare_pkg::REG_BUSY_BACKOFF: backoff = val;
        default: seq_ctr = val;
      endcase
    endfunction

    function void push(logic [1:0] kind, int slot, logic [31:0] dest, logic [15:0] sq,
                       logic [23:0] pre, int okc, int tot, bit allok);
      evt_t e;
      e.kind = kind;
      e.slot = slot[5:0];
      e.dest = dest;
      e.seq = sq;
      e.pid = pre[23:8];
      e.psub = pre[7:0];
      e.scene = scene;
      e.okc = okc[6:0];
      e.tot = tot[6:0];
      e.allok = allok;
      e.last = 0;
      pending.insert(pending.size(), e);
    endfunction

    function int ok_slots();
      int c;
      c = 0;
      for (int i = 0; i < count; i++) if (done[i] && ok[i]) c++;
      return c;
    endfunction

    function void close_if_done();
      int nd;
      int okc;
      nd = 0;
      if (!active) return;
      for (int i = 0; i < count; i++) if (done[i]) nd++;
      if (nd != count) return;
      okc = ok_slots();
      push(msare_pkg::EV_DONE, 0, '0, '0, '0, okc, count, okc == nd && nd > 0);
      dones++;
      active = 0;
    endfunction

    function void note_input(req_t it);
      int n_prior;
      n_prior = pending.size();
      case (it.func)
        msare_pkg::OP_TICK: begin
          if (active) begin
            for (int i = 0; i < count; i++) begin
              if (done[i]) continue;
              if (wait_left[i] != 0) wait_left[i]--;
              if (hold_left[i] != 0) hold_left[i]--;
              if (awaiting[i]) begin
                if (wait_left[i] == 0) awaiting[i] = 0;
                else continue;
              end
              if (hold_left[i] != 0) continue;
              if (att[i] >= max_att) begin
                done[i] = 1;
                ok[i] = 0;
                continue;
              end
              att[i]++;
              seq_ctr++;
              sseq[i] = seq_ctr;
              push(msare_pkg::EV_SEND, i, peer[i], sseq[i], preset[i], 0, 0, 0);
              sends++;
              awaiting[i] = 1;
              wait_left[i] = ack_to;
            end
            close_if_done();
          end
        end
        msare_pkg::OP_REPLY: begin
          if (active) begin
            for (int i = 0; i < count; i++) begin
              if (done[i] || !awaiting[i] || sseq[i] != it.reply_seq ||
                  peer[i] != it.peer_ip) continue;
              if (it.reply_class == msare_pkg::CLS_OK) begin
                done[i] = 1;
                ok[i] = 1;
                awaiting[i] = 0;
              end else if (it.reply_class == msare_pkg::CLS_BUSY) begin
                awaiting[i] = 0;
                hold_left[i] = backoff;
              end else if (it.reply_class == msare_pkg::CLS_ERROR) begin
                done[i] = 1;
                ok[i] = 0;
                awaiting[i] = 0;
              end
              push(msare_pkg::EV_PROGRESS, i, '0, '0, '0, ok_slots(), count, 0);
              progresses++;
            end
            close_if_done();
          end
        end
        msare_pkg::OP_ADD: begin
          if (!active) begin
            if (closed) begin
              count = 0;
              closed = 0;
            end
            if (count < NSLOT) begin
              peer[count] = it.peer_ip;
              preset[count] = {it.pre_num, it.pre_sub};
              count++;
            end
          end
        end
        default: begin
          if (!it.scene_valid) begin
            active = 0;
            closed = 0;
            count = 0;
            scene = '0;
          end else begin
            active = 1;
            closed = 1;
            scene = it.scn_num;
            for (int i = 0; i < count; i++) begin
              sseq[i] = '0;
              att[i] = '0;
              wait_left[i] = '0;
              hold_left[i] = '0;
              awaiting[i] = 0;
              ok[i] = 0;
              done[i] = peer[i] == '0;
            end
          end
        end
      endcase
      if (pending.size() > n_prior) pending[pending.size() - 1].last = 1;
    endfunction

    function string check_result(evt_t got);
      evt_t w;
      string msg;
      if (pending.size() == 0) return "result transaction with nothing expected";
      w = pending.pop_front();
      msg = "";
      if (got.kind !== w.kind) msg = {msg, $sformatf(" kind %0d/%0d", got.kind, w.kind)};
      if (got.slot !== w.slot) msg = {msg, $sformatf(" slot %0d/%0d", got.slot, w.slot)};
      if (got.dest !== w.dest) msg = {msg, $sformatf(" dest %h/%h", got.dest, w.dest)};
      if (got.seq !== w.seq) msg = {msg, $sformatf(" seq %h/%h", got.seq, w.seq)};
      if (got.pid !== w.pid) msg = {msg, $sformatf(" pid %h/%h", got.pid, w.pid)};
      if (got.psub !== w.psub) msg = {msg, $sformatf(" psub %h/%h", got.psub, w.psub)};
      if (got.scene !== w.scene) msg = {msg, $sformatf(" scene %h/%h", got.scene, w.scene)};
      if (got.okc !== w.okc) msg = {msg, $sformatf(" ok %0d/%0d", got.okc, w.okc)};
      if (got.tot !== w.tot) msg = {msg, $sformatf(" total %0d/%0d", got.tot, w.tot)};
      if (got.allok !== w.allok) msg = {msg, $sformatf(" all_ok %b/%b", got.allok, w.allok)};
      if (got.last !== w.last) msg = {msg, $sformatf(" last %b/%b", got.last, w.last)};
      if (msg != "") msg = {"mismatch (got/exp):", msg};
      return msg;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [31:0] in_peer_ip = '0;
  logic [15:0] in_preset_id = '0;
  logic [7:0]  in_preset_sub = '0;
  logic [7:0]  in_scene_index = '0;
  logic        in_scene_valid = 1'b0;
  logic [15:0] in_reply_seq = '0;
  logic [1:0]  in_reply_class = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [5:0]  out_slot_index;
  logic [31:0] out_dest_ip;
  logic [15:0] out_seq;
  logic [15:0] out_preset_id;
  logic [7:0]  out_preset_sub;
  logic [7:0]  out_job_scene;
  logic [6:0]  out_ok_count;
  logic [6:0]  out_total;
  logic        out_all_ok;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  arq_scoreboard sb = new();
  int errors = 0;
  int items = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  multi_slot_ack_retry_engine i_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    evt_t got;
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_event_kind;
      got.slot = out_slot_index;
      got.dest = out_dest_ip;
      got.seq = out_seq;
      got.pid = out_preset_id;
      got.psub = out_preset_sub;
      got.scene = out_job_scene;
      got.okc = out_ok_count;
      got.tot = out_total;
      got.allok = out_all_ok;
      got.last = out_last;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (stall_phase % 5) < 2;
      default: out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic drive_item(input req_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_func <= it.func;
    in_peer_ip <= it.peer_ip;
    in_preset_id <= it.pre_num;
    in_preset_sub <= it.pre_sub;
    in_scene_index <= it.scn_num;
    in_scene_valid <= it.scene_valid;
    in_reply_seq <= it.reply_seq;
    in_reply_class <= it.reply_class;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    burst_left--;
    items++;
  endtask

  function automatic req_t noise_item(msare_pkg::op_t f);
    req_t it;
    it.func = f;
    it.peer_ip = $urandom();
    it.pre_num = 16'($urandom());
    it.pre_sub = 8'($urandom());
    it.scn_num = 8'($urandom());
    it.scene_valid = 1'b1;
    it.reply_seq = 16'($urandom());
    it.reply_class = 2'($urandom());
    return it;
  endfunction

  task automatic add_slot(input logic [31:0] ip, input logic [15:0] pid, input logic [7:0] ps);
    req_t it;
    it = noise_item(msare_pkg::OP_ADD);
    it.peer_ip = ip;
    it.pre_num = pid;
    it.pre_sub = ps;
    drive_item(it);
  endtask

  task automatic commit(input bit sv, input logic [7:0] sc);
    req_t it;
    it = noise_item(msare_pkg::OP_COMMIT);
    it.scene_valid = sv;
    it.scn_num = sc;
    drive_item(it);
  endtask

  task automatic tick();
    drive_item(noise_item(msare_pkg::OP_TICK));
  endtask

  task automatic answer(input int slot, input logic [1:0] cls);
    req_t it;
    it = noise_item(msare_pkg::OP_REPLY);
    it.peer_ip = sb.peer[slot];
    it.reply_seq = sb.sseq[slot];
    it.reply_class = cls;
    drive_item(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input int phase);
    case (phase % 8)
      0: begin
        write_reg(msare_pkg::REG_ACK_TIMEOUT, 16'd1);
        write_reg(msare_pkg::REG_MAX_ATTEMPTS, 16'd15);
        write_reg(msare_pkg::REG_BUSY_BACKOFF, 16'd0);
        write_reg(msare_pkg::REG_SEQ_START, 16'hFFFE);
      end
      1: begin
        write_reg(msare_pkg::REG_ACK_TIMEOUT, 16'hFFFF);
        write_reg(msare_pkg::REG_MAX_ATTEMPTS, 16'd0);
        write_reg(msare_pkg::REG_BUSY_BACKOFF, 16'hFFFF);
        write_reg(msare_pkg::REG_SEQ_START, 16'h0000);
      end
      2: begin
        write_reg(msare_pkg::REG_ACK_TIMEOUT, 16'hFFFF);
        write_reg(msare_pkg::REG_MAX_ATTEMPTS, 16'd3);
        write_reg(msare_pkg::REG_BUSY_BACKOFF, 16'hFFFF);
        write_reg(msare_pkg::REG_SEQ_START, 16'hFFFF);
      end
      default: begin
        write_reg(msare_pkg::REG_ACK_TIMEOUT, 16'($urandom_range(1, 4)));
        write_reg(msare_pkg::REG_MAX_ATTEMPTS, 16'($urandom_range(1, 15)));
        write_reg(msare_pkg::REG_BUSY_BACKOFF, 16'($urandom_range(0, 3)));
        if ($urandom_range(0, 1)) write_reg(msare_pkg::REG_SEQ_START, 16'($urandom()));
      end
    endcase
  endtask

  task automatic run_job();
    int n;
    int pick;
    int cand [$];
    n = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, NSLOT));
    if ($urandom_range(0, 5) == 0) commit(1'b0, 8'($urandom()));
    for (int i = 0; i < n; i++) begin
      add_slot($urandom_range(0, 7) == 0 ? 32'h0 : $urandom(), 16'($urandom()),
               8'($urandom()));
    end
    commit(1'b1, 8'($urandom()));
    for (int k = 0; k < 40 && sb.active; k++) begin
      pick = $urandom_range(0, 99);
      cand.delete();
      for (int i = 0; i < sb.count; i++) begin
        if (sb.awaiting[i] && !sb.done[i]) cand.insert(cand.size(), i);
      end
      if (pick < 45) begin
        tick();
      end else if (pick < 85 && cand.size() != 0) begin
        answer(cand[$urandom_range(0, cand.size() - 1)], 2'($urandom()));
      end else if (pick < 95) begin
        drive_item(noise_item(msare_pkg::OP_REPLY));
      end else if (pick < 97) begin
        add_slot($urandom(), 16'($urandom()), 8'($urandom()));
      end else if (pick < 99) begin
        commit(1'b1, 8'($urandom()));
      end else begin
        commit(1'b0, 8'($urandom()));
      end
    end
  endtask

  initial begin
    int phase;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset register values.
    tick();
    drive_item(noise_item(msare_pkg::OP_REPLY));
    commit(1'b1, 8'h00);
    tick();
    add_slot(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    add_slot(32'h0, 16'h0000, 8'h00);
    commit(1'b1, 8'hFF);
    tick();
    answer(0, msare_pkg::CLS_BUSY);
    answer(0, msare_pkg::CLS_WAIT);
    tick();
    add_slot(32'h1, 16'h1, 8'h1);
    commit(1'b0, 8'hFF);
    for (int i = 0; i <= NSLOT; i++) add_slot(32'h100 + 32'(i), 16'(i), 8'(i));
    commit(1'b1, 8'h5A);
    tick();
    answer(0, msare_pkg::CLS_OK);
    answer(1, msare_pkg::CLS_ERROR);
    drive_item(noise_item(msare_pkg::OP_REPLY));
    settle();

    phase = 0;
    while (items < TARGET_ITEMS - 25) begin
      configure(phase);
      run_job();
      settle();
      phase++;
    end

    settle();
    while (sb.pending.size() != 0) begin
      report("expected result transaction never arrived");
      void'(sb.pending.pop_front());
    end
    $display("Ran %0d input transactions over %0d register settings.", items, phase + 1);
    $display("Checked %0d sends, %0d progress and %0d done transactions.",
             sb.sends, sb.progresses, sb.dones);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/msare_pkg.sv
rtl/msare_cell.sv
rtl/multi_slot_ack_retry_engine.sv
tb/multi_slot_ack_retry_engine_tb.sv
